/* rtl/core/utf8sd_pkg.sv */
`default_nettype none

package utf8sd_pkg;

   // Default width of the saturating character counter.
   localparam int unsigned COUNT_WIDTH_DEF = 16;

   // Field widths of one result.
   localparam int unsigned CP_W     = 21;
   localparam int unsigned DROP_W   = 3;
   localparam int unsigned LEN_W    = 3;
   localparam int unsigned CCOUNT_W = 16;

   // Most results that one byte can cause.
   localparam int unsigned MAX_RES = 3;
   localparam int unsigned NUM_W   = 2;

   // Byte classification masks and patterns.
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_PAT   = 8'h80;
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_PAT  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_PAT  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_PAT  = 8'hF0;

   // Payload masks for continuation and lead bytes.
   localparam logic [7:0] CONT_BITS  = 8'h3F;
   localparam logic [7:0] LEAD2_BITS = 8'h1F;
   localparam logic [7:0] LEAD3_BITS = 8'h0F;
   localparam logic [7:0] LEAD4_BITS = 8'h07;

   // Sequence lengths.
   localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
   localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

   // Open sequence state.
   typedef struct packed {
      logic [CP_W-1:0]  partial_value;
      logic [1:0]       bytes_expected;
      logic [1:0]       bytes_held;
      logic [LEN_W-1:0] sequence_length;
   } seq_state_type;

   // One result item.
   typedef struct packed {
      logic [CP_W-1:0]     code_point;
      logic                valid_res;
      logic [DROP_W-1:0]   dropped_bytes;
      logic [LEN_W-1:0]    seq_length;
      logic [CCOUNT_W-1:0] char_count;
      logic                last;
   } rsp_item_type;

   typedef rsp_item_type [MAX_RES-1:0] rsp_group_type;

endpackage

`default_nettype wire

/* rtl/core/utf8sd_decode.sv */
`default_nettype none

module utf8sd_decode
   import utf8sd_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic [7:0]             data_byte,
   input  wire logic                   end_of_string,
   input  wire seq_state_type          seq_cur,
   input  wire logic [COUNT_WIDTH-1:0] count_cur,
   output seq_state_type               seq_next,
   output logic [COUNT_WIDTH-1:0]      count_next,
   output rsp_group_type               results,
   output logic [NUM_W-1:0]            result_num
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Low 16 bits of the counter, zero-extended for narrow counters.
   function automatic logic [CCOUNT_W-1:0] count_field(input logic [COUNT_WIDTH-1:0] c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[CCOUNT_W-1:0];
   endfunction

   function automatic rsp_item_type make_item(input logic [CP_W-1:0] cp,
                                              input logic valid,
                                              input logic [DROP_W-1:0] dropped,
                                              input logic [LEN_W-1:0] len,
                                              input logic [CCOUNT_W-1:0] cnt,
                                              input logic last);
      rsp_item_type item;
      item.code_point    = cp;
      item.valid_res     = valid;
      item.dropped_bytes = dropped;
      item.seq_length    = len;
      item.char_count    = cnt;
      item.last          = last;
      return item;
   endfunction

   // One pass over the byte: close or extend the open sequence, decode a lead,
   // then close the string if the end flag is set; a zero byte closes it at once.
   always_comb begin
      seq_state_type     st;
      logic [COUNT_WIDTH-1:0] cnt;
      logic [NUM_W-1:0]  n;
      logic              consumed;
      logic [DROP_W-1:0] held_drop;

      st        = seq_cur;
      cnt       = count_cur;
      n         = '0;
      consumed  = 1'b0;
      held_drop = '0;
      results   = '0;

      if (data_byte == 8'h00) begin
         // A zero byte ends the string and is not itself counted.
         held_drop  = (st.bytes_expected != 2'd0) ? {1'b0, st.bytes_held} : '0;
         results[0] = make_item('0, 1'b0, held_drop, '0, count_field(cnt), 1'b1);
         n          = NUM_W'(1);
         st         = '0;
         cnt        = '0;
      end else begin
         // Continue or abandon an open sequence.
         if (st.bytes_expected != 2'd0) begin
            if ((data_byte & CONT_MASK) == CONT_PAT) begin
               consumed         = 1'b1;
               st.partial_value = {st.partial_value[CP_W-7:0], data_byte[5:0] & CONT_BITS[5:0]};
               st.bytes_held    = st.bytes_held + 2'd1;
               st.bytes_expected = st.bytes_expected - 2'd1;
               if (st.bytes_expected == 2'd0) begin
                  if (cnt != COUNT_MAX) begin
                     cnt = cnt + 1'b1;
                  end
                  results[n] = make_item(st.partial_value, 1'b1, '0, st.sequence_length,
                                         count_field(cnt), 1'b0);
                  n          = n + 1'b1;
                  st         = '0;
               end
            end else begin
               results[n] = make_item('0, 1'b0, {1'b0, st.bytes_held}, '0,
                                      count_field(cnt), 1'b0);
               n          = n + 1'b1;
               st         = '0;
            end
         end

         // Read the byte as a lead.
         if (!consumed) begin
            if ((data_byte & ASCII_MASK) == 8'h00) begin
               if (cnt != COUNT_MAX) begin
                  cnt = cnt + 1'b1;
               end
               results[n] = make_item(CP_W'(data_byte), 1'b1, '0, LEN_1,
                                      count_field(cnt), 1'b0);
               n          = n + 1'b1;
            end else if ((data_byte & LEAD2_MASK) == LEAD2_PAT) begin
               st.partial_value   = CP_W'(data_byte & LEAD2_BITS);
               st.bytes_expected  = 2'd1;
               st.bytes_held      = 2'd1;
               st.sequence_length = LEN_2;
            end else if ((data_byte & LEAD3_MASK) == LEAD3_PAT) begin
               st.partial_value   = CP_W'(data_byte & LEAD3_BITS);
               st.bytes_expected  = 2'd2;
               st.bytes_held      = 2'd1;
               st.sequence_length = LEN_3;
            end else if ((data_byte & LEAD4_MASK) == LEAD4_PAT) begin
               st.partial_value   = CP_W'(data_byte & LEAD4_BITS);
               st.bytes_expected  = 2'd3;
               st.bytes_held      = 2'd1;
               st.sequence_length = LEN_4;
            end else begin
               // Stray continuation or an impossible lead.
               results[n] = make_item('0, 1'b0, DROP_W'(1), '0, count_field(cnt), 1'b0);
               n          = n + 1'b1;
            end
         end

         // End flag: report and drop whatever is still open.
         if (end_of_string) begin
            held_drop  = (st.bytes_expected != 2'd0) ? {1'b0, st.bytes_held} : '0;
            results[n] = make_item('0, 1'b0, held_drop, '0, count_field(cnt), 1'b1);
            n          = n + 1'b1;
            st         = '0;
            cnt        = '0;
         end
      end

      seq_next   = st;
      count_next = cnt;
      result_num = n;
   end

endmodule

`default_nettype wire

/* rtl/core/utf8_stream_decoder.sv */
`default_nettype none

// UTF-8 stream decoder. Each request carries one byte of a string and is
// decoded in the cycle it is accepted; the up to three results it causes are
// held in a small result register and leave at one per cycle while rsp_tready
// is high. A new request is taken in the same cycle the last pending result
// leaves, so the sustained rate is one byte per cycle when each byte yields
// at most one result and rsp_tready stays high; otherwise the next byte
// waits for the last result to leave. A zero byte or tlast on a request
// closes the string with an end report (rsp_tlast high) that carries the
// character count and any bytes of an unfinished sequence as dropped bytes.
// Code points are not checked for overlong forms, surrogates or the Unicode
// upper limit.
module utf8_stream_decoder
   import utf8sd_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_string
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [20:0] code_point, [23:21] dropped_bytes,
                                         // [26:24] seq_length, [42:27] char_count,
                                         // [47:43] zero
   output logic [0:0]       rsp_tuser,   // [0] valid_res
   output logic             rsp_tlast    // last
);

   seq_state_type          seq_ff, seq_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   rsp_group_type          res_ff, res_in;
   logic [NUM_W-1:0]       num_ff, num_in;

   seq_state_type          seq_next;
   logic [COUNT_WIDTH-1:0] count_next;
   rsp_group_type          dec_results;
   logic [NUM_W-1:0]       dec_num;
   logic                   req_fire;
   logic                   rsp_fire;

   utf8sd_decode #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_decode (
      .data_byte    (req_tdata),
      .end_of_string(req_tlast),
      .seq_cur      (seq_ff),
      .count_cur    (count_ff),
      .seq_next     (seq_next),
      .count_next   (count_next),
      .results      (dec_results),
      .result_num   (dec_num)
   );

   // Handshakes: a new request is taken once the last pending result leaves.
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (num_ff == '0) || ((num_ff == NUM_W'(1)) && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // Result register: loads a new group or shifts the next result to the front.
   always_comb begin
      seq_in   = seq_ff;
      count_in = count_ff;
      res_in   = res_ff;
      num_in   = num_ff;
      if (rsp_fire) begin
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         res_in[2] = '0;
         num_in    = num_ff - 1'b1;
      end
      if (req_fire) begin
         seq_in   = seq_next;
         count_in = count_next;
         res_in   = dec_results;
         num_in   = dec_num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= '0;
         count_ff <= '0;
         num_ff   <= '0;
      end else begin
         seq_ff   <= seq_in;
         count_ff <= count_in;
         num_ff   <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // Output packing.
   assign rsp_tvalid = (num_ff != '0);
   assign rsp_tdata  = {5'b0, res_ff[0].char_count, res_ff[0].seq_length,
                        res_ff[0].dropped_bytes, res_ff[0].code_point};
   assign rsp_tuser  = res_ff[0].valid_res;
   assign rsp_tlast  = res_ff[0].last;

   // An open sequence always accounts for its full length.
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff.bytes_expected != 2'd0) |->
         ((3'(seq_ff.bytes_held) + 3'(seq_ff.bytes_expected)) == seq_ff.sequence_length))
      else $error("open sequence length does not match bytes held and expected");

   // A zero byte yields exactly one result, the end report, and clears the state.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tdata == 8'h00)) |=>
         ((num_ff == NUM_W'(1)) && res_ff[0].last && (seq_ff == '0) && (count_ff == '0)))
      else $error("zero byte did not produce a single end report");

   // A decoded character never closes the string and never drops bytes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (!rsp_tlast && (res_ff[0].dropped_bytes == '0) && (res_ff[0].seq_length != '0)))
      else $error("valid character result carries drop or end marking");

endmodule

`default_nettype wire

/* tb/sv/tb_utf8_stream_decoder.sv */
`default_nettype none

module tb_utf8_stream_decoder;
   import utf8sd_pkg::*;

   // The character counter keeps its default width.
   localparam int unsigned COUNT_BITS = COUNT_WIDTH_DEF;

   // One pending request: a string byte and its end-of-string flag.
   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } req_byte_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = 8'h00;   // [7:0] data_byte
   logic              req_tlast = 1'b0;    // end_of_string
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [47:0]       rsp_tdata;           // [20:0] code_point, [23:21] dropped_bytes,
                                           // [26:24] seq_length, [42:27] char_count,
                                           // [47:43] zero
   logic [0:0]        rsp_tuser;           // [0] valid_res
   logic              rsp_tlast;           // last

   req_byte_type      pending_bytes[$];
   rsp_item_type      expected_q[$];
   req_byte_type      next_byte;
   rsp_item_type      want;
   logic              idle_ok = 1'b0;
   int                send_gap = 0;
   int                recv_gap = 0;
   int                mismatches = 0;

   // Decoder state kept by the testbench.
   logic [CP_W-1:0]       part_cp = '0;
   logic [1:0]            cont_left = '0;
   logic [1:0]            seq_bytes = '0;
   logic [LEN_W-1:0]      seq_len = '0;
   logic [COUNT_BITS-1:0] char_total = '0;

   utf8_stream_decoder #(
      .COUNT_WIDTH(COUNT_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Expected decoder behavior
   // ---------------------------------------------------------------------

   function automatic void add_result(logic [CP_W-1:0] cp, logic ok,
                                      logic [DROP_W-1:0] drop,
                                      logic [LEN_W-1:0] len, logic fin);
      rsp_item_type r;
      r.code_point    = cp;
      r.valid_res     = ok;
      r.dropped_bytes = drop;
      r.seq_length    = len;
      r.char_count    = CCOUNT_W'(char_total);
      r.last          = fin;
      expected_q.push_back(r);
   endfunction

   function automatic void clear_seq();
      part_cp   = '0;
      cont_left = '0;
      seq_bytes = '0;
      seq_len   = '0;
   endfunction

   function automatic void open_seq(logic [CP_W-1:0] bits, logic [LEN_W-1:0] len);
      part_cp   = bits;
      cont_left = 2'(len - 1);
      seq_bytes = 2'd1;
      seq_len   = len;
   endfunction

   function automatic void bump_count();
      if (char_total != '1) char_total = char_total + 1'b1;
   endfunction

   // The end report drops whatever an open sequence holds and restarts the string.
   function automatic void close_string();
      add_result('0, 1'b0, (cont_left != 0) ? DROP_W'(seq_bytes) : '0, '0, 1'b1);
      clear_seq();
      char_total = '0;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic eos);
      logic taken;
      taken = 1'b0;
      if (b == 8'h00) begin
         close_string();
      end else begin
         // Continue an open sequence, or drop it and reread this byte as a lead.
         if (cont_left != 0) begin
            if ((b & CONT_MASK) == CONT_PAT) begin
               taken     = 1'b1;
               part_cp   = {part_cp[CP_W-7:0], b[5:0]};
               seq_bytes = seq_bytes + 1'b1;
               cont_left = cont_left - 1'b1;
               if (cont_left == 0) begin
                  bump_count();
                  add_result(part_cp, 1'b1, '0, seq_len, 1'b0);
                  clear_seq();
               end
            end else begin
               add_result('0, 1'b0, DROP_W'(seq_bytes), '0, 1'b0);
               clear_seq();
            end
         end
         // Lead byte classification.
         if (!taken) begin
            if ((b & ASCII_MASK) == 8'h00) begin
               bump_count();
               add_result(CP_W'(b), 1'b1, '0, LEN_1, 1'b0);
            end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
               open_seq(CP_W'(b & LEAD2_BITS), LEN_2);
            end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
               open_seq(CP_W'(b & LEAD3_BITS), LEN_3);
            end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
               open_seq(CP_W'(b & LEAD4_BITS), LEN_4);
            end else begin
               add_result('0, 1'b0, DROP_W'(1), '0, 1'b0);
            end
         end
         if (eos) close_string();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------

   task automatic push_byte(logic [7:0] b, logic eos);
      req_byte_type t;
      t.data = b;
      t.eos  = eos;
      pending_bytes.push_back(t);
   endtask

   // A character of len bytes with random payload, cut short after conts
   // continuation bytes.
   task automatic add_char(int len, int conts);
      case (len)
         1:       push_byte(8'($urandom_range(1, 127)), 1'b0);
         2:       push_byte(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
         3:       push_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
         default: push_byte(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
      endcase
      for (int i = 0; i < conts; i++) push_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
   endtask

   // A string of mostly well-formed characters with some noise mixed in (well-formed only
   // when clean is set), closed by a zero byte or by the end flag on its last byte.
   task automatic add_string(int units, bit clean);
      int kind;
      int len;
      req_byte_type t;
      for (int u = 0; u < units; u++) begin
         kind = clean ? 0 : $urandom_range(0, 99);
         if (clean) len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
         else len = $urandom_range(1, 4);
         if (kind < 70) begin
            add_char(len, len - 1);
         end else if (kind < 80) begin
            len = $urandom_range(2, 4);
            add_char(len, $urandom_range(0, len - 2));
         end else if (kind < 87) begin
            push_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
         end else if (kind < 93) begin
            push_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
         end else begin
            push_byte(8'($urandom_range(1, 255)), 1'b0);
         end
      end
      case ($urandom_range(0, 3))
         0: push_byte(8'h00, 1'b0);
         1: push_byte(8'h00, 1'b1);
         default: begin
            t = pending_bytes.pop_back();
            t.eos = 1'b1;
            pending_bytes.push_back(t);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Request driver: idles in short bursts, except in quiet stretches
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_ok    <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               next_byte = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_byte.data;
               req_tlast  <= next_byte.eos;
               if (idle_ok && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 4);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         idle_ok <= pending_bytes.size() >= 60 && (pending_bytes.size() / 40) % 2 == 0;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: stalls in short bursts and checks every field
   // ---------------------------------------------------------------------

   function automatic void check_field(string name, int unsigned exp_val,
                                       int unsigned got_val);
      if (exp_val != got_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("result with no request pending: tdata 0x%0h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               check_field("code_point", want.code_point, rsp_tdata[20:0]);
               check_field("valid_res", want.valid_res, rsp_tuser[0]);
               check_field("dropped_bytes", want.dropped_bytes, rsp_tdata[23:21]);
               check_field("seq_length", want.seq_length, rsp_tdata[26:24]);
               check_field("char_count", want.char_count, rsp_tdata[42:27]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_ok && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 4);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------

   initial begin
      // Single-byte characters, the second at the top of the ASCII range.
      push_byte(8'h41, 1'b0);
      push_byte(8'h7F, 1'b0);
      // Smallest two-byte and largest three- and four-byte values.
      push_byte(8'hC2, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hEF, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hF7, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b0);
      // Stray continuation and bytes that can never lead.
      push_byte(8'h80, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hF8, 1'b0);
      // Missing continuation: the open sequence drops and the byte is reread.
      push_byte(8'hE2, 1'b0);
      push_byte(8'h82, 1'b0);
      push_byte(8'h41, 1'b0);
      // Plain zero terminator.
      push_byte(8'h00, 1'b0);
      // Zero byte while a four-byte sequence is open.
      push_byte(8'hF0, 1'b0);
      push_byte(8'h90, 1'b0);
      push_byte(8'h00, 1'b0);
      // End flag on a byte that breaks an open sequence: three results.
      push_byte(8'hE2, 1'b0);
      push_byte(8'h42, 1'b1);
      // End flag on a lone lead, then on a completing continuation.
      push_byte(8'hC3, 1'b1);
      push_byte(8'hC3, 1'b0);
      push_byte(8'hA9, 1'b1);

      // Random strings, then one clean string and a few short noisy ones.
      while (pending_bytes.size() < 180) add_string($urandom_range(1, 10), 1'b0);
      add_string(30, 1'b1);
      repeat (4) add_string($urandom_range(1, 8), 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_tvalid || expected_q.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);

      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("tb_utf8_stream_decoder: PASS");
      end else begin
         $display("tb_utf8_stream_decoder: FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #4000000;
      $display("tb_utf8_stream_decoder: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
